// ===== hdl/sirc_pkg.sv =====
// Shared types and constants for the stereo convolution reverb core.
// No dependencies; imported by the top level.
package sirc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int Q_FRAC      = 15;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD_COEF = 2'd0;
  localparam cmd_t CMD_SET_TAPS  = 2'd1;
  localparam cmd_t CMD_SAMPLE    = 2'd2;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_ACTIVE_SLOT = 1'b0;
  localparam cfg_index_t CFG_WET_GAIN    = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // unsigned Q2.15 gain, 0..32768
  typedef logic [16:0] gain_t;
  localparam gain_t GAIN_UNITY = 17'd32768;

endpackage

// ===== hdl/sirc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sirc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/stereo_ir_convolution_reverb_core.sv =====
// Top level of the stereo FIR convolution reverb with dry/wet mix.
// Depends on sirc_pkg and sirc_ram (coefficient store and history rings).

// A coefficient load, a tap-count write or an unused command is taken
// from the idle state and returns nothing. When the active slot has no
// taps or the wet gain is zero, a sample passes through and the history is
// left alone: the accept step goes straight to the done state, which hands
// the result to the output register. Otherwise the accept step is followed
// by one tap per cycle through the read ports of the coefficient and
// history RAMs into a single multiply-accumulate, a pipeline drain, the mix
// states MIX1, MIX2 and MIX3 for mix, round and saturate, and the done state
// that hands the result to the output register. The block works on one
// transaction at a time; in_stall is high while a sample is in progress or
// while its result waits for the output register. A result already in the
// output register does not hold off the next transaction. The coefficient
// store is not initialized; load every tap of a slot before using it. The
// history rings read as zero after reset through a per-channel fill count,
// so there is no clearing pass.
module stereo_ir_convolution_reverb_core
  import sirc_pkg::*;
#(
  parameter int MAX_TAPS  = 1024,
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  cmd_t        cmd,
  input  logic        channel,
  input  logic [2:0]  slot,
  input  logic [9:0]  tap_index,
  input  sample_t     value,
  input  logic [10:0] tap_count,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_channel,
  output sample_t     sample_out
);

  localparam int PTR_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CA_DEPTH = NUM_SLOTS * MAX_TAPS;
  localparam int CA_W     = $clog2(CA_DEPTH);
  localparam int HA_DEPTH = 2 * MAX_TAPS;
  localparam int HA_W     = $clog2(HA_DEPTH);
  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int CONV_W   = ACC_W - Q_FRAC;
  localparam int GS_W     = $bits(gain_t) + 1;   // gain as a signed operand
  localparam int MA_W     = CONV_W + GS_W;
  localparam int MB_W     = SAMPLE_BITS + GS_W;
  localparam int MIX_W    = MA_W + 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MIX1  = 3'd3;
  localparam logic [2:0] S_MIX2  = 3'd4;
  localparam logic [2:0] S_MIX3  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // config registers
  logic [2:0]  active_slot;
  logic [15:0] wet_gain;

  // control state
  logic [CNT_W-1:0] slot_taps [NUM_SLOTS];
  logic [PTR_W-1:0] wp   [2];
  logic [CNT_W-1:0] fill [2];
  logic             iss_v1;   // RAM read data valid this cycle
  logic             prod_v;   // product register valid

  // per-transaction working registers
  logic             ch_r;
  sample_t          val_r;
  gain_t            w_r;
  logic [PTR_W-1:0] rd_pos;
  logic [CA_W-1:0]  coef_addr;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] fill_cur;
  logic             hv1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [MA_W-1:0]   mult_a;
  logic signed [MB_W-1:0]   mult_b;
  sample_t                  result;

  // combinational
  logic [31:0]      as_wide;
  logic [SLOT_W-1:0] sel_slot;
  logic [CNT_W-1:0] sel_taps;
  gain_t            w_eff;
  logic             bypass;
  logic             in_acc;
  logic             out_free;
  logic [31:0]      cnt_sat_w;
  logic             ld_ok;
  logic [31:0]      ld_addr_w;
  logic [31:0]      coef_base_w;
  logic [PTR_W-1:0] cur_pos;
  logic [CNT_W-1:0] cur_fill;
  logic [CNT_W-1:0] fill_inc;
  logic [31:0]      hist_waddr_w;
  logic [31:0]      hist_raddr_w;
  logic             hist_we;
  logic             coef_we;
  logic             mac_issue;
  logic [HA_W-1:0]  hist_waddr;
  logic [HA_W-1:0]  hist_raddr;
  logic [SAMPLE_BITS-1:0] hist_rdata;
  logic [SAMPLE_BITS-1:0] coef_rdata;
  logic signed [CONV_W-1:0] conv;
  logic signed [MIX_W-1:0]  mix_sum;
  logic signed [MIX_W-1:0]  mix_sh;

  always_comb begin
    as_wide  = (32'(active_slot) >= 32'(NUM_SLOTS)) ? 32'(NUM_SLOTS - 1)
                                                    : 32'(active_slot);
    sel_slot = as_wide[SLOT_W-1:0];
    sel_taps = slot_taps[sel_slot];
    w_eff    = ({1'b0, wet_gain} > GAIN_UNITY) ? GAIN_UNITY : {1'b0, wet_gain};
    bypass   = (sel_taps == '0) || (w_eff == '0);

    in_acc   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;

    cnt_sat_w   = (32'(tap_count) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(tap_count);
    ld_ok       = (32'(slot) < 32'(NUM_SLOTS)) && (32'(tap_index) < 32'(MAX_TAPS));
    ld_addr_w   = 32'(slot) * 32'(MAX_TAPS) + 32'(tap_index);
    coef_base_w = 32'(sel_slot) * 32'(MAX_TAPS);

    cur_pos  = wp[channel];
    cur_fill = fill[channel];
    fill_inc = (32'(cur_fill) == 32'(MAX_TAPS)) ? cur_fill : cur_fill + 1'b1;

    hist_waddr_w = 32'(cur_pos) + (channel ? 32'(MAX_TAPS) : 32'd0);
    hist_raddr_w = 32'(rd_pos) + (ch_r ? 32'(MAX_TAPS) : 32'd0);
    hist_waddr   = hist_waddr_w[HA_W-1:0];
    hist_raddr   = hist_raddr_w[HA_W-1:0];

    hist_we   = in_acc && (cmd == CMD_SAMPLE) && !bypass;
    coef_we   = in_acc && (cmd == CMD_LOAD_COEF) && ld_ok;
    mac_issue = (state == S_MAC);

    conv    = acc[ACC_W-1:Q_FRAC];   // floor shift by 15
    mix_sum = MIX_W'(mult_a) + MIX_W'(mult_b) + MIX_W'(32'sd16384);
    mix_sh  = mix_sum >>> Q_FRAC;
  end

  assign in_stall = (state != S_IDLE);

  sirc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(CA_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (ld_addr_w[CA_W-1:0]),
    .wdata (value),
    .re    (mac_issue),
    .raddr (coef_addr),
    .rdata (coef_rdata)
  );

  // both channel rings share one RAM, right ring in the upper half
  sirc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HA_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (value),
    .re    (mac_issue),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slot <= '0;
      wet_gain    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_SLOT: active_slot <= cfg_data[2:0];
        CFG_WET_GAIN:    wet_gain    <= cfg_data;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss_v1    <= 1'b0;
      prod_v    <= 1'b0;
      out_valid <= 1'b0;
      wp[0]     <= '0;
      wp[1]     <= '0;
      fill[0]   <= '0;
      fill[1]   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_taps[i] <= '0;
      end
    end else begin
      iss_v1 <= mac_issue;
      prod_v <= iss_v1;

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              CMD_SET_TAPS: begin
                if (32'(slot) < 32'(NUM_SLOTS)) begin
                  slot_taps[slot[SLOT_W-1:0]] <= cnt_sat_w[CNT_W-1:0];
                end
              end
              CMD_SAMPLE: begin
                if (bypass) begin
                  state <= S_DONE;
                end else begin
                  state         <= S_MAC;
                  wp[channel]   <= (32'(cur_pos) == 32'(MAX_TAPS - 1)) ? '0
                                                                      : cur_pos + 1'b1;
                  fill[channel] <= fill_inc;
                end
              end
              default: ;   // coefficient load goes straight to RAM; cmd 3 ignored
            endcase
          end
        end
        S_MAC: begin
          if (remain == CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!iss_v1 && !prod_v) begin
            state <= S_MIX1;
          end
        end
        S_MIX1: state <= S_MIX2;
        S_MIX2: state <= S_MIX3;
        S_MIX3: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      ch_r      <= channel;
      val_r     <= value;
      w_r       <= w_eff;
      rd_pos    <= cur_pos;
      coef_addr <= coef_base_w[CA_W-1:0];
      remain    <= sel_taps;
      fill_cur  <= fill_inc;
      acc       <= '0;
      result    <= value;   // bypass result
    end

    if (mac_issue) begin
      // entries at or past the fill count were never written: read as zero
      hv1       <= (rd_pos < PTR_W'(fill_cur)) || (32'(fill_cur) == 32'(MAX_TAPS));
      rd_pos    <= (rd_pos == '0) ? PTR_W'(MAX_TAPS - 1) : rd_pos - 1'b1;
      coef_addr <= coef_addr + 1'b1;
      remain    <= remain - 1'b1;
    end

    if (iss_v1) begin
      if (hv1) begin
        prod <= $signed(coef_rdata) * $signed(hist_rdata);
      end else begin
        prod <= '0;
      end
    end
    if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end

    if (state == S_MIX1) begin
      mult_a <= conv * $signed({1'b0, w_r});
    end
    if (state == S_MIX2) begin
      mult_b <= val_r * $signed({1'b0, GAIN_UNITY - w_r});
    end
    if (state == S_MIX3) begin
      priority if (mix_sh > MIX_W'(SAMPLE_MAX)) begin
        result <= SAMPLE_MAX;
      end else if (mix_sh < MIX_W'(SAMPLE_MIN)) begin
        result <= SAMPLE_MIN;
      end else begin
        result <= mix_sh[SAMPLE_BITS-1:0];
      end
    end

    if (state == S_DONE && out_free) begin
      out_channel <= ch_r;
      sample_out  <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_pipe_in_mac: assert property (@(posedge clk) disable iff (rst)
    iss_v1 |-> (state == S_DRAIN || state == S_MAC))
    else $error("MAC read data outside the accumulate phase");

  a_mix_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX1) |-> (!iss_v1 && !prod_v))
    else $error("mix started before the accumulator settled");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (remain != '0))
    else $error("tap issue with no taps left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(fill[0]) <= 32'(MAX_TAPS)) && (32'(fill[1]) <= 32'(MAX_TAPS)))
    else $error("history fill count past ring size");
`endif

endmodule
